/* rtl/spq_pkg.sv */
// spq_pkg: shared types and constants of the sorted priority queue.
// Item structs, request and status codes, queue depth.
// No dependencies.
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 5;

  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] in_value;
    logic signed [15:0] in_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

/* rtl/spq_cell.sv */
// spq_cell: one slot of the sorted queue chain.
// Holds one entry; shifts toward tail on insert, toward head on removal.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  logic      occupied,
  input  logic      left_keep,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      keep,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // entry stays put when it outranks or ties the newcomer
  assign keep  = occupied && (entry_r.prio >= new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.enq) begin
      if (!keep) begin
        entry_nxt = left_keep ? new_entry : left_entry;
      end
    end else if (ctl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* rtl/sorted_priority_queue_unit.sv */
// Sorted priority queue top level: cell chain, occupancy count, result register.
// Result registered: valid in the cycle after acceptance. Throughput: 1 item per
// cycle unless a result stalls; set by the chain's single compare-and-shift step.
// Reset (rst_n low, synchronous): queue empty, no result pending; entry storage
// is not cleared and holds no meaning until written.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_unit import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic      accept;
  logic      is_full, is_empty;
  cell_ctl_t ctl;
  entry_t    new_entry;

  logic   [DEPTH-1:0] occ;
  logic   [DEPTH-1:0] keep;
  entry_t             cell_entry [DEPTH];

  // Result register parts the two sides: a new item enters unless a
  // finished result is still waiting behind a stalled output.
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  assign new_entry.value = in_item.in_value;
  assign new_entry.prio  = in_item.in_priority;

  // Chain moves only for requests that change the queue.
  assign ctl.enq = accept && (in_item.req_type == REQ_ENQ) && !is_full;
  assign ctl.deq = accept && (in_item.req_type == REQ_DEQ) && !is_empty;

  // Cell chain. Head is cell 0. On insert each cell compares its own
  // priority with the newcomer; the first cell that does not keep its
  // entry takes the newcomer and the ones after it take the left neighbor.
  // On removal every cell takes its right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_k;

    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_k = 1'b1;
      assign left_e = new_entry;
    end else begin : g_body
      assign left_k = keep[i-1];
      assign left_e = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_mid
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .occupied    (occ[i]),
      .left_keep   (left_k),
      .left_entry  (left_e),
      .right_entry (right_e),
      .keep        (keep[i]),
      .entry       (cell_entry[i])
    );
  end

  // Occupancy and result of the accepted item.
  always_comb begin
    count_nxt    = count_r;
    out_item_nxt = out_item_r;
    if (ctl.enq) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.deq) begin
      count_nxt = count_r - 1'b1;
    end

    if (accept) begin
      out_item_nxt.out_value = '0;
      out_item_nxt.status    = ST_OK;
      case (in_item.req_type)
        REQ_ENQ: begin
          if (is_full) begin
            out_item_nxt.status = ST_OVERFLOW;
          end
        end
        REQ_DEQ, REQ_PEEK: begin
          if (is_empty) begin
            out_item_nxt.status = ST_EMPTY;
          end else begin
            out_item_nxt.out_value = cell_entry[0].value;
          end
        end
        default: begin
          // unused code: no operation
        end
      endcase
      out_item_nxt.occupancy = OCC_W'(count_nxt);
    end

    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

endmodule

/* rtl/spq_checker.sv */
// spq_checker: port-level assertions for the sorted priority queue.
// Bound to sorted_priority_queue_unit; depends on spq_pkg.
module spq_checker import spq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // every accepted item gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // input waits only behind a stalled pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_EMPTY |->
      out_item.out_value == '0 && out_item.occupancy == '0)
    else $error("empty status with data or entries");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

/* tb/sv/tb_sorted_priority_queue_unit.sv */
// Self-checking testbench for sorted_priority_queue_unit: random and directed requests
// checked against an in-bench sorted-list model of the queue.
// Depends on spq_pkg and the sorted_priority_queue_unit RTL.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  // request code 3 is unused by the block and must behave as a no-op
  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam int RANDOM_ITEMS   = 550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  sorted_priority_queue_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // pending requests for the driver, expected results for the monitor
  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];

  int accepted_reqs = 0;
  int total_reqs    = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  // shadow copy of the sorted list, head at index 0
  logic signed [31:0] shadow_value[DEPTH];
  logic signed [15:0] shadow_prio[DEPTH];
  int                 shadow_count = 0;

  // no idling on either side over one stretch of the run
  logic calm;
  assign calm = (accepted_reqs >= 250) && (accepted_reqs < 400);

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      shadow_value[i] = '0;
      shadow_prio[i]  = '0;
    end
  end

  // apply one request to the shadow list and return the result it must produce
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t res;
    int        n;
    int        pos;
    res = '0;
    res.status = ST_OK;
    n = shadow_count;
    if (req.req_type == REQ_ENQ) begin
      if (n >= DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < n && shadow_prio[pos] >= req.in_priority) pos++;
        for (int k = n; k > pos; k--) begin
          shadow_value[k] = shadow_value[k-1];
          shadow_prio[k]  = shadow_prio[k-1];
        end
        shadow_value[pos] = req.in_value;
        shadow_prio[pos]  = req.in_priority;
        n++;
      end
    end else if (req.req_type == REQ_DEQ || req.req_type == REQ_PEEK) begin
      if (n == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_value = shadow_value[0];
        if (req.req_type == REQ_DEQ) begin
          for (int k = 1; k < n; k++) begin
            shadow_value[k-1] = shadow_value[k];
            shadow_prio[k-1]  = shadow_prio[k];
          end
          n--;
        end
      end
    end
    shadow_count = n;
    res.occupancy = n[OCC_W-1:0];
    return res;
  endfunction

  task automatic queue_req(logic [1:0] kind, logic [31:0] value, logic [15:0] prio);
    in_item_t it;
    it.req_type    = kind;
    it.in_value    = value;
    it.in_priority = prio;
    pending_reqs.push_back(it);
  endtask

  function automatic logic [15:0] pick_prio();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return 16'($signed($urandom_range(8)) - 4);   // dense ties
    if (roll < 60) return 16'($signed($urandom_range(400)) - 200);
    if (roll < 70) begin
      case ($urandom_range(2))
        0:       return 16'h7fff;
        1:       return 16'h8000;
        default: return 16'h0000;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 80) return $urandom;
    case ($urandom_range(3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // driver: a new item only when the channel is free; a stalled item is held
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
        in_item  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 36);
    end
  end

  // monitor: check the accepted result first, then predict for the accepted request,
  // both from values sampled before the edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: value %0d status %0d occupancy %0d",
                     out_item.out_value, out_item.status, out_item.occupancy);
        end else begin
          want = expected_results.pop_front();
          if (out_item.out_value !== want.out_value || out_item.status !== want.status ||
              out_item.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: expected value %0d status %0d occupancy %0d, ",
                        "got value %0d status %0d occupancy %0d"},
                       want.out_value, want.status, want.occupancy,
                       out_item.out_value, out_item.status, out_item.occupancy);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(serve_request(in_item));
        accepted_reqs <= accepted_reqs + 1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int         counted;
    int         roll;
    int         mode;
    logic [1:0] kind;

    // directed: empty head access, no-op code, extremes, ties, full queue, overflow
    queue_req(REQ_PEEK, 32'h1234_5678, 16'h7fff);
    queue_req(REQ_DEQ,  32'hffff_ffff, 16'h8000);
    queue_req(REQ_NOP,  32'hdead_beef, 16'h5a5a);
    queue_req(REQ_ENQ,  32'h7fff_ffff, 16'h7fff);
    queue_req(REQ_ENQ,  32'h8000_0000, 16'h8000);
    queue_req(REQ_ENQ,  32'h0000_0000, 16'h0000);
    queue_req(REQ_PEEK, 32'h0,         16'h0);
    for (int i = 0; i < 5; i++) queue_req(REQ_ENQ, 32'(100 + i), 16'h0005);   // ties
    queue_req(REQ_ENQ,  32'hffff_ffff, 16'hffff);
    for (int i = 0; i < 8; i++) queue_req(REQ_ENQ, $urandom, 16'($urandom));
    queue_req(REQ_ENQ,  32'h5555_aaaa, 16'h7fff);   // overflow, highest priority
    queue_req(REQ_ENQ,  32'haaaa_5555, 16'h8000);   // overflow, lowest priority
    queue_req(REQ_NOP,  32'h0,         16'h0);
    queue_req(REQ_PEEK, 32'h0,         16'h0);
    queue_req(REQ_DEQ,  32'h0,         16'h0);
    queue_req(REQ_DEQ,  32'h0,         16'h0);

    // random: fill, drain or mixed phases picked at random so the queue swings between empty and full
    counted = 0;
    mode = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0) mode = $urandom_range(2);
      roll = $urandom_range(99);
      if (roll < 5) begin
        kind = REQ_NOP;
      end else begin
        roll = $urandom_range(99);
        case (mode)
          0:       kind = (roll < 70) ? REQ_ENQ : ((roll < 88) ? REQ_DEQ : REQ_PEEK);
          1:       kind = (roll < 25) ? REQ_ENQ : ((roll < 85) ? REQ_DEQ : REQ_PEEK);
          default: kind = (roll < 45) ? REQ_ENQ : ((roll < 80) ? REQ_DEQ : REQ_PEEK);
        endcase
      end
      counted++;
      // non-enqueue requests carry random fields that must be ignored
      queue_req(kind, pick_value(), pick_prio());
    end
    total_reqs = pending_reqs.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_reqs < total_reqs || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
rtl/spq_checker.sv
tb/sv/tb_sorted_priority_queue_unit.sv
